FILE: src/anfd_pkg.sv
// ----------------------------------------------------------------------------
// anfd_pkg
// Shared types, constants and helpers for the ANF degree block.
// ----------------------------------------------------------------------------
package anfd_pkg;

    localparam int NV_W  = 3;   // width of the num_vars register
    localparam int IDX_W = 6;   // width of the coefficient index field
    localparam int DEG_W = 3;   // width of the degree field

    localparam logic [NV_W-1:0] NV_RESET = 3'd6;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_XFORM,
        ST_XGAP,
        ST_XDRAIN,
        ST_EMIT
    } t_state;

    // Status from the emit stage back to the sequencer.
    typedef struct packed {
        logic busy;
        logic rd_en;
    } t_emit_stat;

    function automatic logic [DEG_W-1:0] bit_weight(input logic [IDX_W-1:0] v);
        logic [DEG_W-1:0] w;
        w = '0;
        for (int i = 0; i < IDX_W; i++) begin
            w = w + DEG_W'(v[i]);
        end
        return w;
    endfunction

endpackage

FILE: src/anfd_ram.sv
// ----------------------------------------------------------------------------
// anfd_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module anfd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

FILE: src/anfd_emit.sv
// ----------------------------------------------------------------------------
// anfd_emit
// Streams the coefficients out of the table memory, one word per cycle
// while the output is not stalled, through the RAM read register and an output register.
// ----------------------------------------------------------------------------
module anfd_emit
    import anfd_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [AW-1:0]     i_last_idx,
    input  logic [DEG_W-1:0]  i_degree,
    output logic [AW-1:0]     o_rd_addr,
    input  logic              i_rd_data,
    output t_emit_stat        o_stat,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [15:0]       o_m_axis_tdata,  // [5:0] coeff_index, [6] coeff_value,
                                               // [9:7] algebraic_degree
    output logic              o_m_axis_tlast   // last_of_run
);

    logic              r_active;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_last_idx;
    logic              r_s1_v;
    logic [AW-1:0]     r_s1_idx;
    logic              r_s1_last;
    logic              r_o_v;
    logic [IDX_W-1:0]  r_o_idx;
    logic              r_o_val;
    logic [DEG_W-1:0]  r_o_deg;
    logic              r_o_last;

    logic out_free;
    logic s1_move;
    logic issue;

    assign out_free = !r_o_v || i_m_axis_tready;
    assign s1_move  = r_s1_v && out_free;
    assign issue    = r_active && (!r_s1_v || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_s1_v   <= 1'b0;
            r_o_v    <= 1'b0;
        end else begin
            if (i_start) begin
                r_active   <= 1'b1;
                r_idx      <= '0;
                r_last_idx <= i_last_idx;
            end else if (issue) begin
                if (r_idx == r_last_idx) begin
                    r_active <= 1'b0;
                end
                r_idx <= r_idx + AW'(1);
            end

            if (issue) begin
                r_s1_v    <= 1'b1;
                r_s1_idx  <= r_idx;
                r_s1_last <= (r_idx == r_last_idx);
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end

            // advance the read word into the output register, or drop a taken word
            if (s1_move) begin
                r_o_v    <= 1'b1;
                r_o_idx  <= IDX_W'(r_s1_idx);
                r_o_val  <= i_rd_data;
                r_o_deg  <= i_degree;
                r_o_last <= r_s1_last;
            end else if (i_m_axis_tready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    assign o_rd_addr       = r_idx;
    assign o_stat.rd_en    = issue;
    assign o_stat.busy     = r_active || r_s1_v;
    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = {6'd0, r_o_deg, r_o_val, r_o_idx};
    assign o_m_axis_tlast  = r_o_last;

endmodule

FILE: src/boolean_anf_degree.sv
// ----------------------------------------------------------------------------
// boolean_anf_degree
// Loads a truth table one bit per word, runs the Moebius butterfly in place
// in the table memory, tracks the algebraic degree and streams the ANF.
//
//   channel   dir  fields                                           handshake
//   s_axis    in   entry_bit                                        tvalid/tready
//   m_axis    out  coeff_index, coeff_value, algebraic_degree, last tvalid/tready
//   cfg       in   num_vars                                         write enable
//
// Sequence: a run of N = 2^n words is loaded word by word, then the butterfly
// runs stage by stage (one pair per cycle over two read ports, one write-back
// per pair, a gap state between stages), then the N words are emitted.
// The degree is folded in during the final stage.
// No input is taken while the butterfly or the emit runs. Output stalls
// hold the emit pipeline. Reset is synchronous; the table needs no clearing.
// ----------------------------------------------------------------------------
module boolean_anf_degree
    import anfd_pkg::*;
#(
    parameter int MAX_VARS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [NV_W-1:0]   i_cfg_wdata,       // num_vars
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,    // [0] entry_bit
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [15:0]       o_m_axis_tdata,    // [5:0] coeff_index, [6] coeff_value,
                                                 // [9:7] algebraic_degree
    output logic              o_m_axis_tlast     // last_of_run
);

    localparam int AW    = MAX_VARS;
    localparam int DEPTH = 1 << MAX_VARS;

    t_state            r_state, n_state;
    logic [NV_W-1:0]   r_num_vars;
    logic [AW:0]       r_load_cnt, n_load_cnt;
    logic [NV_W-1:0]   r_bit, n_bit;
    logic [AW-1:0]     r_pair, n_pair;
    logic [DEG_W-1:0]  r_max_w, n_max_w;
    logic              r_pend;
    logic [AW-1:0]     r_pend_lo, r_pend_hi;
    logic              r_pend_fin;

    logic [NV_W-1:0]   nv_act;
    logic [AW:0]       size_v;
    logic [AW:0]       half_v;
    logic [AW-1:0]     pair_last;
    logic [AW-1:0]     low_mask;
    logic [AW-1:0]     lo_addr, hi_addr;
    logic              in_acc;
    logic              xf_issue;
    logic              emit_start;
    logic              fin_stage;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_wdata;
    logic              ram_re_a;
    logic [AW-1:0]     ram_raddr_a;
    logic              rdata_a, rdata_b;
    logic              hi_new;
    logic [DEG_W-1:0]  w_lo, w_hi, w_max;

    logic [AW-1:0]     emit_addr;
    t_emit_stat        emit_stat;

    assign nv_act    = (r_num_vars > NV_W'(MAX_VARS)) ? NV_W'(MAX_VARS) : r_num_vars;
    assign size_v    = (AW+1)'(1) << nv_act;
    assign half_v    = size_v >> 1;
    assign pair_last = AW'(half_v - (AW+1)'(1));
    assign fin_stage = (r_bit == nv_act - NV_W'(1));

    // pair index with a zero inserted at the stage bit
    assign low_mask = (AW'(1) << r_bit) - AW'(1);
    assign lo_addr  = ((r_pair & ~low_mask) << 1) | (r_pair & low_mask);
    assign hi_addr  = lo_addr | (AW'(1) << r_bit);

    assign in_acc          = i_s_axis_tvalid && (r_state == ST_LOAD);
    assign o_s_axis_tready = (r_state == ST_LOAD);

    // write-back of the pair read last cycle, and its degree contribution
    assign hi_new = rdata_a ^ rdata_b;
    assign w_lo   = rdata_a ? bit_weight(IDX_W'(r_pend_lo)) : '0;
    assign w_hi   = hi_new  ? bit_weight(IDX_W'(r_pend_hi)) : '0;
    assign w_max  = (w_lo > w_hi) ? w_lo : w_hi;

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_bit      = r_bit;
        n_pair     = r_pair;
        n_max_w    = r_max_w;
        xf_issue   = 1'b0;
        emit_start = 1'b0;

        if (r_pend && r_pend_fin && (w_max > r_max_w)) begin
            n_max_w = w_max;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (i_cfg_we) begin
                    n_load_cnt = '0;
                end else if (in_acc) begin
                    if (r_load_cnt + (AW+1)'(1) == size_v) begin
                        n_load_cnt = '0;
                        n_bit      = '0;
                        n_pair     = '0;
                        n_max_w    = '0;
                        if (nv_act == '0) begin
                            n_state    = ST_EMIT;
                            emit_start = 1'b1;
                        end else begin
                            n_state = ST_XFORM;
                        end
                    end else begin
                        n_load_cnt = r_load_cnt + (AW+1)'(1);
                    end
                end
            end
            ST_XFORM: begin
                xf_issue = 1'b1;
                if (r_pair == pair_last) begin
                    n_pair = '0;
                    if (fin_stage) begin
                        n_state = ST_XDRAIN;
                    end else begin
                        n_bit   = r_bit + NV_W'(1);
                        n_state = ST_XGAP;
                    end
                end else begin
                    n_pair = r_pair + AW'(1);
                end
            end
            // let the last write of a stage land before the next stage reads
            ST_XGAP: begin
                n_state = ST_XFORM;
            end
            ST_XDRAIN: begin
                n_state    = ST_EMIT;
                emit_start = 1'b1;
            end
            ST_EMIT: begin
                if (!emit_stat.busy) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_num_vars <= NV_RESET;
            r_load_cnt <= '0;
            r_max_w    <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_max_w    <= n_max_w;
            r_pend     <= xf_issue;
            if (i_cfg_we) begin
                r_num_vars <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit      <= n_bit;
        r_pair     <= n_pair;
        r_pend_lo  <= lo_addr;
        r_pend_hi  <= hi_addr;
        r_pend_fin <= fin_stage;
    end

    assign ram_we      = in_acc || r_pend;
    assign ram_waddr   = r_pend ? r_pend_hi : r_load_cnt[AW-1:0];
    assign ram_wdata   = r_pend ? hi_new : i_s_axis_tdata[0];
    assign ram_re_a    = (r_state == ST_EMIT) ? emit_stat.rd_en : xf_issue;
    assign ram_raddr_a = (r_state == ST_EMIT) ? emit_addr : lo_addr;

    anfd_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re_a    (ram_re_a),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (rdata_a),
        .i_re_b    (xf_issue),
        .i_raddr_b (hi_addr),
        .o_rdata_b (rdata_b)
    );

    anfd_emit #(
        .AW (AW)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (emit_start),
        .i_last_idx      (AW'(size_v - (AW+1)'(1))),
        .i_degree        (r_max_w),
        .o_rd_addr       (emit_addr),
        .i_rd_data       (rdata_a),
        .o_stat          (emit_stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // load writes and butterfly write-backs never share the write port
    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && r_pend))
        else $error("load write collides with butterfly write-back");

    // a new emit run starts only after the previous one has drained
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_start |-> !emit_stat.busy)
        else $error("emit started while busy");

    // a pending write-back always follows a butterfly read
    a_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xf_issue |=> r_pend && (r_state == ST_XFORM || r_state == ST_XGAP
                                || r_state == ST_XDRAIN))
        else $error("write-back without butterfly state");

    // the load count stays inside the table
    a_cnt_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_load_cnt < size_v))
        else $error("load count beyond table size");

endmodule
